// ----- src/vsd_pkg.sv -----
package vsd_pkg;

  // sizing
  localparam int MAX_ROW_LENGTH = 1024;
  localparam int SAMPLE_BITS    = 16;
  localparam int COL_BITS       = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int LEN_BITS       = 11;
  localparam int ROW_BITS       = 16;
  localparam int GAIN_BITS      = 32;
  localparam int FRAC_BITS      = 16;
  localparam int DENSITY_BITS   = 32;
  localparam int DIFF_BITS      = SAMPLE_BITS + 3;
  localparam int PROD_BITS      = DIFF_BITS + GAIN_BITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_BITS   = 2;

  // register reset values
  localparam logic [LEN_BITS-1:0]  ROW_LENGTH_RESET = LEN_BITS'(16);
  localparam logic [ROW_BITS-1:0]  FRAME_ROWS_RESET = ROW_BITS'(16);
  localparam logic [GAIN_BITS-1:0] GAIN_RESET       = GAIN_BITS'(65536);

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_FRAME_ROWS = 2'd1,
    REG_GAIN       = 2'd2
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [DENSITY_BITS-1:0] density_t;
  typedef logic [ROW_BITS-1:0]            row_t;
  typedef logic [COL_BITS-1:0]            col_t;
  typedef logic [CFG_IDX_BITS-1:0]        cfg_index_t;
  typedef logic [GAIN_BITS-1:0]           cfg_data_t;

  // one queue entry: the lagging result and the last-row result of one sample
  typedef struct packed {
    density_t density0;
    density_t density1;
    row_t     row;
    col_t     col;
    logic     has0;
    logic     has1;
    logic     done;
  } result_pair_t;

endpackage

// ----- src/vsd_if.sv -----
interface vsd_in_if import vsd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface vsd_out_if import vsd_pkg::*; ();
  logic     valid;
  logic     ready;
  density_t density;
  row_t     row_index;
  col_t     column_index;
  logic     frame_done;
  modport source(output valid, output density, output row_index, output column_index,
                 output frame_done, input ready);
  modport sink(input valid, input density, input row_index, input column_index,
               input frame_done, output ready);
endinterface

interface vsd_cfg_if import vsd_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- src/vertical_second_difference_filter.sv -----
// Vertical second difference filter over a raster stream of signed samples.
// Channels: cfg writes row_length, frame_rows and gain (Q16.16) by index;
// samples takes one sample per request in row-major order, top row first;
// results gives density = floor(gain * (above - 2*here + below) / 2^16),
// saturated to 32 bits, tagged with row, column and a frame_done flag.
// Rows beyond the top and bottom edges repeat the edge row.
// A result for row r leaves once the same column of row r+1 is taken, so
// output lags input by one row. On the last row each sample gives two
// results: the lagging one for the row above and its own.
// Throughput is one sample per cycle while results is ready; on the last row it
// is lower, set by the single result per cycle on the output side. The line
// store is one RAM holding both earlier rows per column, read and written once
// per sample; a sample's results pass stage 1, stage 2 and the result queue.
// Reset clears the counters, the result queue and the registers to their
// defaults (16 columns, 16 rows, gain 1.0); the line store is not cleared.
// When results stalls, a four-entry queue absorbs work in flight and
// samples.ready drops once the queue cannot take more.
module vertical_second_difference_filter import vsd_pkg::*; (
  input logic       clk,
  input logic       rst,
  vsd_cfg_if.sink   cfg,
  vsd_in_if.sink    samples,
  vsd_out_if.source results
);

  typedef logic signed [DIFF_BITS-1:0]            diff_t;
  typedef logic signed [PROD_BITS-1:0]            prod_t;
  typedef logic [2*SAMPLE_BITS-1:0]               word_t;

  function automatic density_t saturate(prod_t p);
    logic signed [PROD_BITS-FRAC_BITS-1:0] q;
    density_t r;
    q = p[PROD_BITS-1:FRAC_BITS];
    if (!q[PROD_BITS-FRAC_BITS-1] && (|q[PROD_BITS-FRAC_BITS-2:DENSITY_BITS-1])) begin
      r = {1'b0, {(DENSITY_BITS-1){1'b1}}};
    end else if (q[PROD_BITS-FRAC_BITS-1] &&
                 !(&q[PROD_BITS-FRAC_BITS-2:DENSITY_BITS-1])) begin
      r = {1'b1, {(DENSITY_BITS-1){1'b0}}};
    end else begin
      r = q[DENSITY_BITS-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [LEN_BITS-1:0]  row_length;
  logic [ROW_BITS-1:0]  frame_rows;
  logic [GAIN_BITS-1:0] gain;

  // raster position
  col_t col_count, col_count_next;
  row_t row_count, row_count_next;

  // stage 1: line store word arrives
  logic    v1;
  sample_t s1_sample;
  col_t    s1_col;
  row_t    s1_row;
  logic    s1_last, s1_eol, s1_ge1, s1_ge2;
  logic    s1_fwd;
  word_t   s1_fwd_word;

  // stage 2: products registered
  logic  v2;
  prod_t s2_prod0, s2_prod1;
  row_t  s2_row;
  col_t  s2_col;
  logic  s2_has0, s2_has1, s2_done;

  // result queue
  result_pair_t           queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]   q_count;
  logic                   half;

  logic                   in_take, push, pop, show_second;
  logic [LEN_BITS-1:0]    len_eff, col_plus;
  logic [ROW_BITS-1:0]    rows_eff;
  logic [ROW_BITS:0]      row_plus;
  logic                   last, eol;
  word_t                  rd_word, cur_word, wr_word;
  sample_t                cur_prev, cur_older, above0, above1;
  diff_t                  diff0, diff1;
  prod_t                  prod0, prod1;
  logic [QCNT_BITS-1:0]   in_flight;
  result_pair_t           head;

  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      frame_rows <= FRAME_ROWS_RESET;
      gain       <= GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW_LENGTH: row_length <= cfg.data[LEN_BITS-1:0];
        REG_FRAME_ROWS: frame_rows <= cfg.data[ROW_BITS-1:0];
        REG_GAIN:       gain       <= cfg.data[GAIN_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // position decode for the incoming sample
  always_comb begin
    if (row_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (row_length > LEN_BITS'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_BITS'(MAX_ROW_LENGTH);
    end else begin
      len_eff = row_length;
    end
    rows_eff = (frame_rows == '0) ? ROW_BITS'(1) : frame_rows;
    col_plus = LEN_BITS'(col_count) + LEN_BITS'(1);
    row_plus = {1'b0, row_count} + (ROW_BITS+1)'(1);
    eol      = col_plus >= len_eff;
    last     = row_plus >= {1'b0, rows_eff};
    if (eol) begin
      col_count_next = '0;
      row_count_next = last ? '0 : row_plus[ROW_BITS-1:0];
    end else begin
      col_count_next = col_plus[COL_BITS-1:0];
      row_count_next = row_count;
    end
  end

  // accept while the queue has room for everything in flight
  assign in_flight     = q_count + QCNT_BITS'(v1) + QCNT_BITS'(v2);
  assign samples.ready = in_flight < QCNT_BITS'(QUEUE_DEPTH);
  assign in_take       = samples.valid && samples.ready;

  // line store: previous row in the upper half, older row in the lower half
  vsd_ram #(
    .WIDTH(2*SAMPLE_BITS),
    .DEPTH(MAX_ROW_LENGTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (v1),
    .waddr(s1_col),
    .wdata(wr_word),
    .raddr(col_count),
    .rdata(rd_word)
  );

  // stage 1 arithmetic, with the word just written forwarded on a collision
  always_comb begin
    cur_word  = s1_fwd ? s1_fwd_word : rd_word;
    cur_prev  = cur_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
    cur_older = cur_word[SAMPLE_BITS-1:0];
    wr_word   = {s1_sample, cur_prev};
    above0    = s1_ge2 ? cur_older : cur_prev;
    above1    = s1_ge1 ? cur_prev : s1_sample;
    diff0     = diff_t'(above0) - (diff_t'(cur_prev) <<< 1) + diff_t'(s1_sample);
    diff1     = diff_t'(above1) - diff_t'(s1_sample);
    prod0     = prod_t'(diff0) * prod_t'({1'b0, gain});
    prod1     = prod_t'(diff1) * prod_t'({1'b0, gain});
  end

  // raster counters and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      if (in_take) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      v1 <= in_take;
      v2 <= v1;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_sample   <= samples.sample;
    s1_col      <= col_count;
    s1_row      <= row_count;
    s1_last     <= last;
    s1_eol      <= eol;
    s1_ge1      <= row_count != '0;
    s1_ge2      <= row_count > ROW_BITS'(1);
    s1_fwd      <= v1 && (s1_col == col_count);
    s1_fwd_word <= wr_word;
    s2_prod0    <= prod0;
    s2_prod1    <= prod1;
    s2_row      <= s1_row;
    s2_col      <= s1_col;
    s2_has0     <= s1_ge1;
    s2_has1     <= s1_last;
    s2_done     <= s1_last && s1_eol;
  end

  // result queue and output sequencing
  assign push        = v2 && (s2_has0 || s2_has1);
  assign head        = queue[rd_ptr];
  assign show_second = half || !head.has0;
  assign pop         = results.valid && results.ready && (show_second || !head.has1);

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{density0: saturate(s2_prod0), density1: saturate(s2_prod1),
                         row: s2_row, col: s2_col, has0: s2_has0, has1: s2_has1,
                         done: s2_done};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
      half    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      q_count <= q_count + QCNT_BITS'(push) - QCNT_BITS'(pop);
      if (results.valid && results.ready) begin
        half <= !pop;
      end
    end
  end

  // output fields
  assign results.valid        = q_count != '0;
  assign results.density      = show_second ? head.density1 : head.density0;
  assign results.row_index    = show_second ? head.row : head.row - ROW_BITS'(1);
  assign results.column_index = head.col;
  assign results.frame_done   = show_second && head.done;

endmodule

// ----- src/vsd_ram.sv -----
module vsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read returning the old word on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
